// File: src/aes_pkg.sv
// AES-256 package: payload structs, S-box tables, GF(2^8) helpers.
// Used by every module of aes256_block_cipher; no dependencies.
package aes_pkg;

  localparam int unsigned NumRounds = 14;
  localparam int unsigned NumKeyRegs = 4;

  typedef struct packed {
    logic        operation;
    logic [63:0] block_in_high;
    logic [63:0] block_in_low;
  } in_word_t;

  typedef struct packed {
    logic [63:0] block_out_high;
    logic [63:0] block_out_low;
  } out_word_t;

  localparam logic [1:0] CfgKeyWord0 = 2'd0;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Forward MixColumns on one column, byte 0 in [31:24].
  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    mix_col = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
               a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
               a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
               xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  // Inverse MixColumns: pre-multiply by (04 x^2 + 05) then forward mix.
  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3, u, v;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    u = xtime(xtime(a0 ^ a2));
    v = xtime(xtime(a1 ^ a3));
    inv_mix_col = mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
  endfunction

  function automatic logic [127:0] mix_state(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      r[127-32*c -: 32] = inv ? inv_mix_col(s[127-32*c -: 32]) : mix_col(s[127-32*c -: 32]);
    end
    mix_state = r;
  endfunction

  // SubBytes+ShiftRows, or their inverses. Byte i sits at [127-8i -: 8].
  function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    int unsigned mv;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        mv = r + 4 * ((c + r) % 4);
        if (!inv) begin
          t[127-8*(r+4*c) -: 8] = SBOX[s[127-8*mv -: 8]];
        end else begin
          t[127-8*mv -: 8] = INV_SBOX[s[127-8*(r+4*c) -: 8]];
        end
      end
    end
    sub_shift = t;
  endfunction

endpackage

// File: src/aes_key_expand.sv
// AES-256 key expansion: one 32-bit schedule word per cycle into two round-key stores.
// Depends on aes_pkg. Writes encrypt keys in order and decrypt keys reversed.
module aes_key_expand (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [255:0] key,
  output logic         busy,
  input  logic [3:0]   rd_round,
  input  logic         rd_dec,
  output logic [127:0] rd_key
);

  typedef enum logic [1:0] {
    KE_IDLE = 2'b01,
    KE_RUN  = 2'b10
  } ke_state_t;

  ke_state_t state_r, state_nxt;
  logic [5:0]   idx_r, idx_nxt;     // schedule word index 8..59
  logic [255:0] win_r, win_nxt;     // last eight words, newest at [31:0]
  logic [7:0]   rcon_r, rcon_nxt;
  logic [127:0] enc_mem [15];
  logic [127:0] dec_mem [15];
  logic [127:0] rd_q_r;
  logic [31:0]  t_rot, t_sub, t_new;
  logic [127:0] rk_done;
  logic [3:0]   rk_num;
  logic         wr_en;

  always_comb begin
    t_rot = (idx_r[2:0] == 3'd0) ? {win_r[23:0], win_r[31:24]} : win_r[31:0];
    t_sub = t_rot;
    if (idx_r[1:0] == 2'd0) begin
      t_sub = {aes_pkg::SBOX[t_rot[31:24]], aes_pkg::SBOX[t_rot[23:16]],
               aes_pkg::SBOX[t_rot[15:8]], aes_pkg::SBOX[t_rot[7:0]]};
    end
    if (idx_r[2:0] == 3'd0) begin
      t_sub = t_sub ^ {rcon_r, 24'h0};
    end
    t_new = win_r[255:224] ^ t_sub;
  end

  // A round key completes once its fourth word is in; the first two need
  // no generated word and are written at start.
  assign rk_done = {win_r[95:0], t_new};
  assign rk_num  = 4'(idx_r >> 2);
  assign wr_en   = (state_r == KE_RUN) && (idx_r[1:0] == 2'd3);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    win_nxt   = win_r;
    rcon_nxt  = rcon_r;
    unique case (state_r)
      KE_IDLE: begin
        if (start) begin
          state_nxt = KE_RUN;
          idx_nxt   = 6'd8;
          win_nxt   = key;
          rcon_nxt  = 8'h01;
        end
      end
      KE_RUN: begin
        win_nxt = {win_r[223:0], t_new};
        idx_nxt = idx_r + 6'd1;
        if (idx_r[2:0] == 3'd0) rcon_nxt = aes_pkg::xtime(rcon_r);
        if (idx_r == 6'd59) state_nxt = KE_IDLE;
      end
      default: state_nxt = KE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= KE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    idx_r  <= idx_nxt;
    win_r  <= win_nxt;
    rcon_r <= rcon_nxt;
  end

  always_ff @(posedge clk) begin
    if (state_r == KE_IDLE && start) begin
      enc_mem[0]  <= key[255:128];
      enc_mem[1]  <= key[127:0];
      dec_mem[14] <= key[255:128];
      dec_mem[13] <= aes_pkg::mix_state(key[127:0], 1'b1);
    end else if (wr_en) begin
      enc_mem[rk_num] <= rk_done;
      dec_mem[4'd14 - rk_num] <= (rk_num == 4'd14) ? rk_done
                                : aes_pkg::mix_state(rk_done, 1'b1);
    end
    rd_q_r <= rd_dec ? dec_mem[rd_round] : enc_mem[rd_round];
  end

  assign rd_key = rd_q_r;
  assign busy   = (state_r == KE_RUN);

endmodule

// File: src/aes_round_core.sv
// AES iterative round datapath: one shared round unit reused for all 14 rounds.
// Depends on aes_pkg. Round key comes registered from the key store.
module aes_round_core (
  input  logic         clk,
  input  logic         load,
  input  logic [127:0] din,
  input  logic         dec,
  input  logic         whiten,
  input  logic         last,
  input  logic         step,
  input  logic [127:0] rkey,
  output logic [127:0] state
);

  logic [127:0] st_r, st_nxt, ss, mx;

  always_comb begin
    ss = aes_pkg::sub_shift(st_r, dec);
    mx = aes_pkg::mix_state(ss, dec);
    st_nxt = st_r;
    priority if (load) begin
      st_nxt = din;
    end else if (step) begin
      if (whiten)    st_nxt = st_r ^ rkey;
      else if (last) st_nxt = ss ^ rkey;
      else           st_nxt = mx ^ rkey;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign state = st_r;

endmodule

// File: src/aes256_block_cipher.sv
// AES-256 ECB cipher top level.
// Depends on aes_pkg, aes_key_expand and aes_round_core.
//
// Usage:
//  - Key: four 64-bit words written through cfg_we/cfg_index/cfg_data,
//    word 0 holding key bytes 0..7. Every write to index 0..3 restarts the
//    key schedule (one schedule word per cycle); cfg_index has no other
//    values. After reset the all-zero key is expanded at once.
//  - Input: in_valid/in_ready carry one word: operation bit plus a 128-bit
//    block. in_ready is low while the schedule runs or a block is in work.
//  - Rounds: one shared round unit; a registered key-store read, then
//    whitening plus 14 rounds at one per cycle, then out_valid rises.
//    One block at a time: the next block waits until this one is done.
//  - Output: out_valid/out_ready; the result sits in a register until
//    taken, and a new block is accepted only once the result is taken.
module aes256_block_cipher (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  aes_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output aes_pkg::out_word_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data
);

  typedef enum logic [3:0] {
    ST_INIT  = 4'b0001,  // start schedule after reset / key write
    ST_IDLE  = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_OUT   = 4'b1000
  } top_state_t;

  top_state_t state_r, state_nxt;
  logic [63:0]  key_r [aes_pkg::NumKeyRegs];
  logic         kick_r;          // pending schedule restart
  logic [3:0]   rnd_r, rnd_nxt;  // round key being read
  logic         rd_vld_r;        // key data valid for step
  logic [3:0]   use_r;           // round number of key on rd_key
  logic         dec_r;
  logic         ke_busy;
  logic [127:0] rd_key, core_state;
  logic         load, step;

  // Key registers; a write requests a fresh expansion.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < aes_pkg::NumKeyRegs; i++) key_r[i] <= '0;
      kick_r <= 1'b1;
    end else begin
      if (cfg_we) begin
        key_r[cfg_index] <= cfg_data;
        kick_r <= 1'b1;
      end else if (state_r == ST_INIT && !ke_busy) begin
        kick_r <= 1'b0;
      end
    end
  end

  aes_key_expand u_kexp (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_INIT && !ke_busy && !cfg_we),
    .key      ({key_r[0], key_r[1], key_r[2], key_r[3]}),
    .busy     (ke_busy),
    .rd_round (rnd_r),
    .rd_dec   (dec_r),
    .rd_key   (rd_key)
  );

  assign in_ready = (state_r == ST_IDLE) && !kick_r && !ke_busy;
  assign load     = in_valid && in_ready;
  assign step     = (state_r == ST_RUN) && rd_vld_r;

  aes_round_core u_core (
    .clk    (clk),
    .load   (load),
    .din    ({in_data.block_in_high, in_data.block_in_low}),
    .dec    (dec_r),
    .whiten (use_r == 4'd0),
    .last   (use_r == 4'(aes_pkg::NumRounds)),
    .step   (step),
    .rkey   (rd_key),
    .state  (core_state)
  );

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    unique case (state_r)
      ST_INIT: if (!ke_busy && !cfg_we) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (kick_r) state_nxt = ST_INIT;
        else if (load) begin
          state_nxt = ST_RUN;
          rnd_nxt   = 4'd0;
        end
      end
      ST_RUN: begin
        if (rnd_r != 4'(aes_pkg::NumRounds)) rnd_nxt = rnd_r + 4'd1;
        if (step && use_r == 4'(aes_pkg::NumRounds)) state_nxt = ST_OUT;
      end
      ST_OUT: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_INIT;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == ST_RUN) && (state_nxt == ST_RUN);
    end
    rnd_r <= rnd_nxt;
    use_r <= rnd_r;
    if (load) dec_r <= in_data.operation;
  end

  assign out_valid = (state_r == ST_OUT);
  assign out_data  = '{block_out_high: core_state[127:64],
                       block_out_low:  core_state[63:0]};

endmodule

// File: src/aes256_block_cipher_chk.sv
// Port-level checker for aes256_block_cipher, bound to the top level.
// Depends on aes_pkg for the port types.
module aes256_block_cipher_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input aes_pkg::out_word_t out_data,
  input logic               cfg_we
);

  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready while result pending");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("block not held in work");

  a_no_ready_on_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready) else $error("ready during key reload");

endmodule

bind aes256_block_cipher aes256_block_cipher_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data), .cfg_we(cfg_we)
);
